// ===== design/srs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_pkg
// shared types and constants of the stepper ramp sequencer
// ----------------------------------------------------------------------------
package srs_pkg;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_TICK = 2'd0;
	localparam cmd_t CMD_MOVE = 2'd1;
	localparam cmd_t CMD_HOME = 2'd2;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_MAX_DELAY   = 3'd0;
	localparam reg_idx_t REG_MIN_DELAY   = 3'd1;
	localparam reg_idx_t REG_PATTERNS    = 3'd2;
	localparam reg_idx_t REG_HOME_DELAY  = 3'd3;
	localparam reg_idx_t REG_HOME_OFFSET = 3'd4;

	localparam logic [7:0]  MAX_DELAY_RST   = 8'd15;
	localparam logic [7:0]  MIN_DELAY_RST   = 8'd7;
	localparam logic [31:0] PATTERNS_RST    = 32'd0;
	localparam logic [7:0]  HOME_DELAY_RST  = 8'd30;
	localparam logic [7:0]  HOME_OFFSET_RST = 8'd2;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_MOVE   = 4'b0010,
		MODE_SEARCH = 4'b0100,
		MODE_OFFSET = 4'b1000
	} mode_t;

endpackage

// ===== design/stepper_ramp_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_ramp_sequencer
// four-phase stepper sequencer with trapezoidal ramp and homing run
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  command   cmd_valid cmd_ready command step_count     in
//            hall_level
//  result    res_valid res_ready coil_pattern busy_res  out
//            done_res position phase_index
//  config    cfg_we cfg_index cfg_wdata                 in, write only
//
//  one item per cycle sustained while results are taken; a result comes from
//  its command through the input register, then the result register
//  the state update and result of an item are one short pass of counter and
//  compare logic between the input register and the result register
//  arst_n clears control state and loads the register reset values
//  a stalled result holds; a new command is still taken while the input
//  register is empty or moving forward into a free result register
// ----------------------------------------------------------------------------
module stepper_ramp_sequencer
	import srs_pkg::*;
#(
	parameter int POSITIONS_PER_TURN = 200,
	parameter int PHASE_COUNT        = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// command channel
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  logic [1:0]        command,
	input  logic signed [15:0] step_count,
	input  logic              hall_level,
	// result channel
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        coil_pattern,
	output logic              busy_res,
	output logic              done_res,
	output logic [7:0]        position,
	output logic [1:0]        phase_index,
	// configuration writes
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [31:0]       cfg_wdata
);

	// position and phase registers are at least as wide as their output fields
	localparam int POS_W = ($clog2(POSITIONS_PER_TURN) > 8) ? $clog2(POSITIONS_PER_TURN) : 8;
	localparam int PH_W  = ($clog2(PHASE_COUNT) > 2) ? $clog2(PHASE_COUNT) : 2;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(POSITIONS_PER_TURN - 1);
	localparam logic [PH_W-1:0]  PH_LAST  = PH_W'(PHASE_COUNT - 1);

	// configuration registers
	logic [7:0]  max_delay_q, min_delay_q, home_delay_q, home_offset_q;
	logic [31:0] patterns_q;

	// input register
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] step_s1;
	logic        hall_s1;

	// sequencer state
	mode_t            mode_q, n_mode;
	logic [PH_W-1:0]  phase_q, n_phase;
	logic [7:0]       pat_q, n_pat;
	logic [POS_W-1:0] pos_q, n_pos;
	logic [POS_W-1:0] shadow_q, n_shadow;   // running position during a move
	logic [15:0]      steps_q, n_steps;
	logic             dir_q, n_dir;         // 1 steps forward
	logic [7:0]       cur_q, n_cur;
	logic [7:0]       eff_q, n_eff;
	logic [7:0]       tick_q, n_tick;
	logic [7:0]       off_q, n_off;
	logic             n_done;

	// result register
	logic             res_valid_q;
	logic [7:0]       coil_q;
	logic             busy_q, done_q;
	logic [7:0]       position_q;
	logic [1:0]       phase_idx_q;

	logic adv;

	// ---- helpers ----------------------------------------------------------
	// the phase register always holds 0..PHASE_COUNT-1
	function automatic logic [PH_W-1:0] ph_fwd(input logic [PH_W-1:0] ph);
		return (ph == PH_LAST) ? '0 : PH_W'(ph + 1'b1);
	endfunction

	function automatic logic [PH_W-1:0] ph_back(input logic [PH_W-1:0] ph);
		return (ph == '0) ? PH_LAST : PH_W'(ph - 1'b1);
	endfunction

	function automatic logic [7:0] pat_of(input logic [PH_W-1:0] ph, input logic [31:0] pats);
		return 8'(pats >> {ph[1:0], 3'b000});
	endfunction

	function automatic logic [POS_W-1:0] pos_step(input logic [POS_W-1:0] p, input logic back);
		logic [POS_W-1:0] r;
		if (back) begin
			r = (p == '0) ? POS_LAST : POS_W'(p - 1'b1);
		end else begin
			r = (p >= POS_LAST) ? '0 : POS_W'(p + 1'b1);
		end
		return r;
	endfunction

	// ramp: speed up while far from the end, slow down toward max near it
	function automatic logic [7:0] next_delay(input logic [7:0] cur, input logic [15:0] left,
			input logic [7:0] maxd, input logic [7:0] eff);
		logic [7:0] gap;
		logic [8:0] thr;
		logic [7:0] r;
		gap = (maxd >= eff) ? 8'(maxd - eff) : 8'd0;
		thr = {1'b0, gap} + 9'd2;
		if (left > 16'(thr)) begin
			r = (cur > eff) ? 8'(cur - 1'b1) : eff;
		end else begin
			r = (cur < maxd) ? 8'(cur + 1'b1) : maxd;
		end
		return r;
	endfunction

	// ---- configuration ------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_delay_q   <= MAX_DELAY_RST;
			min_delay_q   <= MIN_DELAY_RST;
			patterns_q    <= PATTERNS_RST;
			home_delay_q  <= HOME_DELAY_RST;
			home_offset_q <= HOME_OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_DELAY:   max_delay_q   <= cfg_wdata[7:0];
				REG_MIN_DELAY:   min_delay_q   <= cfg_wdata[7:0];
				REG_PATTERNS:    patterns_q    <= cfg_wdata;
				REG_HOME_DELAY:  home_delay_q  <= cfg_wdata[7:0];
				REG_HOME_OFFSET: home_offset_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// ---- flow control -------------------------------------------------------
	// the input register moves on when the result register is free or drains
	assign adv       = valid_s1 && (!res_valid_q || res_ready);
	assign cmd_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1  <= command;
			step_s1 <= step_count;
			hall_s1 <= hall_level;
		end
	end

	// ---- next state of one item --------------------------------------------
	logic             neg, nz;
	logic [15:0]      mag;
	logic [7:0]       mn, gap0;
	logic [PH_W-1:0]  ph_a;
	logic [POS_W-1:0] sh_a;
	logic [7:0]       tick_inc, wait_d;
	logic             over;
	logic [15:0]      steps_dec;

	always_comb begin
		n_mode   = mode_q;
		n_phase  = phase_q;
		n_pat    = pat_q;
		n_pos    = pos_q;
		n_shadow = shadow_q;
		n_steps  = steps_q;
		n_dir    = dir_q;
		n_cur    = cur_q;
		n_eff    = eff_q;
		n_tick   = tick_q;
		n_off    = off_q;
		n_done   = 1'b0;

		// move start terms
		neg  = step_s1[15];
		nz   = (step_s1 != 16'd0);
		mag  = neg ? 16'(-step_s1) : step_s1;
		mn   = (min_delay_q > max_delay_q) ? max_delay_q : min_delay_q;
		gap0 = 8'(max_delay_q - mn);
		if (mag < 16'({gap0, 1'b0})) begin
			// short move never reaches full speed
			mn = 8'(max_delay_q - mag[8:1]);
		end
		ph_a = nz ? (neg ? ph_back(phase_q) : ph_fwd(phase_q)) : phase_q;
		sh_a = nz ? pos_step(pos_q, neg) : pos_q;

		// tick wait, a zero delay counts as one tick
		wait_d   = (mode_q == MODE_MOVE) ? cur_q : home_delay_q;
		tick_inc = 8'(tick_q + 1'b1);
		over     = (tick_inc >= ((wait_d == 8'd0) ? 8'd1 : wait_d));
		steps_dec = (steps_q != 16'd0) ? 16'(steps_q - 1'b1) : 16'd0;

		case (cmd_s1)
			CMD_MOVE: begin
				if (mode_q == MODE_IDLE) begin
					n_eff   = mn;
					n_cur   = max_delay_q;
					n_dir   = !neg;
					n_tick  = 8'd0;
					n_phase = ph_a;
					n_pat   = pat_of(ph_a, patterns_q);
					if (mag <= 16'd1) begin
						n_steps = 16'd0;
						n_pos   = sh_a;
						n_done  = 1'b1;
					end else begin
						n_steps  = 16'(mag - 1'b1);
						n_shadow = sh_a;
						n_mode   = MODE_MOVE;
						n_cur    = next_delay(max_delay_q, 16'(mag - 1'b1), max_delay_q, mn);
					end
				end
			end
			CMD_HOME: begin
				if (mode_q == MODE_IDLE) begin
					n_tick = 8'd0;
					if (hall_s1) begin
						// sensor already active: a zero offset ends at once with coils off, else phase 0, then the offset
						if (home_offset_q == 8'd0) begin
							n_pat   = 8'd0;
							n_phase = PH_LAST;
							n_pos   = '0;
							n_done  = 1'b1;
						end else begin
							n_phase = ph_fwd(PH_LAST);
							n_pat   = pat_of(ph_fwd(PH_LAST), patterns_q);
							n_off   = 8'(home_offset_q - 1'b1);
							n_mode  = MODE_OFFSET;
						end
					end else begin
						n_phase = '0;
						n_pat   = pat_of('0, patterns_q);
						n_mode  = MODE_SEARCH;
					end
				end
			end
			CMD_TICK: begin
				case (mode_q)
					MODE_MOVE: begin
						if (over) begin
							n_tick  = 8'd0;
							n_phase = dir_q ? ph_fwd(phase_q) : ph_back(phase_q);
							n_pat   = pat_of(n_phase, patterns_q);
							n_steps = steps_dec;
							if (steps_dec == 16'd0) begin
								n_pos  = pos_step(shadow_q, !dir_q);
								n_mode = MODE_IDLE;
								n_done = 1'b1;
							end else begin
								n_shadow = pos_step(shadow_q, !dir_q);
								n_cur    = next_delay(cur_q, steps_dec, max_delay_q, eff_q);
							end
						end else begin
							n_tick = tick_inc;
						end
					end
					MODE_SEARCH: begin
						if (over) begin
							n_tick = 8'd0;
							if (hall_s1 && home_offset_q == 8'd0) begin
								n_pos  = '0;
								n_mode = MODE_IDLE;
								n_done = 1'b1;
							end else begin
								n_phase = ph_fwd(phase_q);
								n_pat   = pat_of(ph_fwd(phase_q), patterns_q);
								if (hall_s1) begin
									n_off  = 8'(home_offset_q - 1'b1);
									n_mode = MODE_OFFSET;
								end
							end
						end else begin
							n_tick = tick_inc;
						end
					end
					MODE_OFFSET: begin
						if (over) begin
							n_tick = 8'd0;
							if (off_q == 8'd0) begin
								n_pos  = '0;
								n_mode = MODE_IDLE;
								n_done = 1'b1;
							end else begin
								n_phase = ph_fwd(phase_q);
								n_pat   = pat_of(ph_fwd(phase_q), patterns_q);
								n_off   = 8'(off_q - 1'b1);
							end
						end else begin
							n_tick = tick_inc;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// ---- state registers ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			phase_q  <= '0;
			pat_q    <= 8'd0;
			pos_q    <= '0;
			shadow_q <= '0;
			steps_q  <= 16'd0;
			dir_q    <= 1'b0;
			cur_q    <= MAX_DELAY_RST;
			eff_q    <= MIN_DELAY_RST;
			tick_q   <= 8'd0;
			off_q    <= 8'd0;
		end else if (adv) begin
			mode_q   <= n_mode;
			phase_q  <= n_phase;
			pat_q    <= n_pat;
			pos_q    <= n_pos;
			shadow_q <= n_shadow;
			steps_q  <= n_steps;
			dir_q    <= n_dir;
			cur_q    <= n_cur;
			eff_q    <= n_eff;
			tick_q   <= n_tick;
			off_q    <= n_off;
		end
	end

	// ---- result register ---------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			coil_q      <= n_pat;
			busy_q      <= (n_mode != MODE_IDLE);
			done_q      <= n_done;
			position_q  <= n_pos[7:0];
			phase_idx_q <= n_phase[1:0];
		end
	end

	assign res_valid    = res_valid_q;
	assign coil_pattern = coil_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign position     = position_q;
	assign phase_index  = phase_idx_q;

endmodule

// ===== design/srs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srs_checker
// port level checks of the stepper ramp sequencer
// ----------------------------------------------------------------------------
module srs_checker #(
	parameter int POSITIONS_PER_TURN = 200,
	parameter int PHASE_COUNT        = 4
) (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] coil_pattern,
	input logic       busy_res,
	input logic       done_res,
	input logic [7:0] position,
	input logic [1:0] phase_index
);

	// a stalled result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(coil_pattern) && $stable(position)
			&& $stable(phase_index) && $stable(busy_res) && $stable(done_res))
		else $error("result changed while stalled");

	// a finishing item leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && done_res |-> !busy_res)
		else $error("done reported while still busy");

	// position stays inside one turn
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (POSITIONS_PER_TURN > 256) || (position < POSITIONS_PER_TURN))
		else $error("position out of range");

	// phase stays inside the coil sequence
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (PHASE_COUNT > 4) || (phase_index < PHASE_COUNT))
		else $error("phase index out of range");

endmodule

bind stepper_ramp_sequencer srs_checker #(
	.POSITIONS_PER_TURN(POSITIONS_PER_TURN),
	.PHASE_COUNT(PHASE_COUNT)
) u_srs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.res_valid(res_valid),
	.res_ready(res_ready),
	.coil_pattern(coil_pattern),
	.busy_res(busy_res),
	.done_res(done_res),
	.position(position),
	.phase_index(phase_index)
);
